[src/obm_pkg.sv]
// Shared types and codes for the limit order book matcher.
package obm_pkg;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_CANCEL  = 2'd1,
		CMD_REDUCE  = 2'd2,
		CMD_REPLACE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		TIF_GTC = 2'd0,
		TIF_GFD = 2'd1,
		TIF_IOC = 2'd2,
		TIF_FOK = 2'd3
	} tif_t;

	typedef enum logic [1:0] {
		STP_CANCEL_NEW     = 2'd0,
		STP_CANCEL_RESTING = 2'd1,
		STP_CANCEL_BOTH    = 2'd2,
		STP_DECREMENT      = 2'd3
	} stp_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_NO_FILL   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_QTY   = 3'd4,
		ST_CANCELLED = 3'd5,
		ST_REDUCED   = 3'd6,
		ST_BOOK_FULL = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		OC_NONE           = 3'd0,
		OC_FILLED         = 3'd1,
		OC_RESTED         = 3'd2,
		OC_REM_CANCELLED  = 3'd3,
		OC_STP_NEW        = 3'd4,
		OC_STP_BOTH       = 3'd5,
		OC_STP_DEC_FILLED = 3'd6,
		OC_STP_DEC_RESTED = 3'd7
	} outcome_t;

	typedef struct packed {
		logic        is_trade;
		logic [63:0] resting_id;
		logic [31:0] trade_price;
		logic [31:0] qty_a;
		logic [31:0] qty_b;
		logic [5:0]  trades_done;
		status_t     status;
		outcome_t    outcome;
		logic        last;
	} res_t;

endpackage

[src/obm_cmd_if.sv]
// Command channel: one order book command per item.
interface obm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] new_order_id;
	logic [63:0] target_id;
	logic        buy_side;
	logic [31:0] limit_price;
	logic [31:0] amount;
	logic        is_market;
	logic [1:0]  tif;
	logic [31:0] stp_group;
	logic [1:0]  stp_rule;

	modport source (output valid, cmd, new_order_id, target_id, buy_side, limit_price,
		amount, is_market, tif, stp_group, stp_rule, input ready);
	modport sink (input valid, cmd, new_order_id, target_id, buy_side, limit_price,
		amount, is_market, tif, stp_group, stp_rule, output ready);
	modport monitor (input valid, ready, cmd, new_order_id, target_id, buy_side,
		limit_price, amount, is_market, tif, stp_group, stp_rule);
endinterface

[src/obm_rpt_if.sv]
// Report channel: trades and final status, one per item.
interface obm_rpt_if;
	logic        valid;
	logic        ready;
	logic        is_trade;
	logic [63:0] resting_id;
	logic [31:0] trade_price;
	logic [31:0] qty_a;
	logic [31:0] qty_b;
	logic [5:0]  trades_done;
	logic [2:0]  status;
	logic [2:0]  outcome;
	logic        last;

	modport source (output valid, is_trade, resting_id, trade_price, qty_a, qty_b,
		trades_done, status, outcome, last, input ready);
	modport sink (input valid, is_trade, resting_id, trade_price, qty_a, qty_b,
		trades_done, status, outcome, last, output ready);
	modport monitor (input valid, ready, is_trade, resting_id, trade_price, qty_a, qty_b,
		trades_done, status, outcome, last);
endinterface

[src/obm_prio_cmp.sv]
// Price-time priority compare used by every step of the best-order search.
module obm_prio_cmp (
	input  logic        buy_in,
	input  logic        best_valid,
	input  logic [31:0] cand_price,
	input  logic [31:0] cand_age,
	input  logic [31:0] best_price,
	input  logic [31:0] best_age,
	output logic        take
);
	logic better_price;

	// A buyer prefers the lowest ask, a seller the highest bid.
	assign better_price = buy_in ? (cand_price < best_price) : (cand_price > best_price);

	always_comb begin
		if (!best_valid) begin
			take = 1'b1;
		end else if (cand_price != best_price) begin
			take = better_price;
		end else begin
			// At equal price the older order wins; equal ages keep the lower index, as slots are scanned upward.
			take = cand_age > best_age;
		end
	end
endmodule

[src/limit_order_book_matcher.sv]
// Top level of the limit order book matcher: sequencer, slot store and report register.
//
// Commands arrive on the orders channel and are taken one at a time; ready is high
// only while the block is idle. Each command produces zero or more trade items and
// then exactly one final item with last set, all on the reports channel.
// Searches scan the BOOK_DEPTH slots one per cycle through a single read port; the
// best-order search also uses the shared priority compare unit. An id lookup scans
// the whole book and then decides; each match step (trade or self-trade action)
// follows a full search, and a last search that finds nothing ends the matching.
// A fill-or-kill check first walks the book the same way for each order it inspects.
// Resting the remainder searches for a free slot, and then the final item is loaded;
// the block is idle and takes the next command in the cycle after that load.
// Results leave through an output register; when the receiver stalls, the
// sequencer holds at its next result until the register is free.
// Reset empties the book and clears the arrival counter; no clearing pass is needed.
module limit_order_book_matcher #(
	parameter int BOOK_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	obm_cmd_if.sink orders,
	obm_rpt_if.source reports
);
	import obm_pkg::*;

	localparam int IW = $clog2(BOOK_DEPTH);
	typedef logic [IW-1:0] idx_t;
	localparam idx_t LAST_IDX = idx_t'(BOOK_DEPTH - 1);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_FIND   = 8'b0000_0010,
		S_DECIDE = 8'b0000_0100,
		S_SRCH   = 8'b0000_1000,
		S_STEP   = 8'b0001_0000,
		S_AFTER  = 8'b0010_0000,
		S_FREE   = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [BOOK_DEPTH-1:0] slot_valid_q;
	logic [63:0] slot_id_q [BOOK_DEPTH];
	logic        slot_buy_q [BOOK_DEPTH];
	logic [31:0] slot_price_q [BOOK_DEPTH];
	logic [31:0] slot_qty_q [BOOK_DEPTH];
	logic [31:0] slot_grp_q [BOOK_DEPTH];
	logic [31:0] slot_arr_q [BOOK_DEPTH];
	logic [31:0] ctr_q;

	cmd_t        cmd_q;
	logic [63:0] nid_q;
	logic [63:0] tid_q;
	logic        buy_q;
	logic [31:0] lim_q;
	logic [31:0] amt_q;
	logic        mkt_q;
	tif_t        tif_q;
	logic [31:0] grp_q;
	stp_t        pol_q;

	idx_t        idx_q;
	idx_t        tgt_q;
	logic        tgt_found_q;
	logic        dup_q;
	logic [31:0] tgt_qty_q;
	logic        fok_q;
	logic [31:0] need_q;
	logic [31:0] rem_q;
	logic [BOOK_DEPTH-1:0] visited_q;
	logic        bfound_q;
	idx_t        best_q;
	logic [31:0] best_price_q;
	logic [31:0] best_age_q;
	logic [5:0]  nt_q;
	logic        dec_q;
	status_t     fin_st_q;
	outcome_t    fin_oc_q;
	logic [31:0] fin_qa_q;
	logic [31:0] fin_qb_q;

	logic        out_valid_q;
	res_t        out_q;

	idx_t        rd_idx;
	logic        rd_valid;
	logic [63:0] rd_id;
	logic        rd_buy;
	logic [31:0] rd_price;
	logic [31:0] rd_qty;
	logic [31:0] rd_grp;
	logic [31:0] rd_age;
	logic        elig;
	logic        take;
	logic        scan_end;
	logic        stp_hit;
	logic [31:0] tq;
	logic        out_free;
	logic        out_load;
	logic        fail_stp;

	always_comb begin
		unique case (state_q)
			S_DECIDE: rd_idx = tgt_q;
			S_STEP:   rd_idx = best_q;
			default:  rd_idx = idx_q;
		endcase
	end

	assign rd_valid = slot_valid_q[rd_idx];
	assign rd_id    = slot_id_q[rd_idx];
	assign rd_buy   = slot_buy_q[rd_idx];
	assign rd_price = slot_price_q[rd_idx];
	assign rd_qty   = slot_qty_q[rd_idx];
	assign rd_grp   = slot_grp_q[rd_idx];
	assign rd_age   = ctr_q - slot_arr_q[rd_idx];

	assign elig = rd_valid && (rd_buy != buy_q) && !visited_q[rd_idx] &&
		(mkt_q || (buy_q ? (rd_price <= lim_q) : (rd_price >= lim_q)));
	assign scan_end = (idx_q == LAST_IDX);
	assign stp_hit  = (grp_q != 32'd0) && (rd_grp == grp_q);
	assign tq       = (rem_q < rd_qty) ? rem_q : rd_qty;
	assign out_free = !out_valid_q || reports.ready;
	assign fail_stp = stp_hit && (pol_q == STP_CANCEL_NEW || pol_q == STP_CANCEL_BOTH);

	// The report register is loaded by a trade step or by the final item.
	assign out_load = out_free && ((state_q == S_FIN) ||
		(state_q == S_STEP && !fok_q && !stp_hit));

	obm_prio_cmp u_cmp (
		.buy_in     (buy_q),
		.best_valid (bfound_q),
		.cand_price (rd_price),
		.cand_age   (rd_age),
		.best_price (best_price_q),
		.best_age   (best_age_q),
		.take       (take)
	);

	assign orders.ready        = (state_q == S_IDLE);
	assign reports.valid       = out_valid_q;
	assign reports.is_trade    = out_q.is_trade;
	assign reports.resting_id  = out_q.resting_id;
	assign reports.trade_price = out_q.trade_price;
	assign reports.qty_a       = out_q.qty_a;
	assign reports.qty_b       = out_q.qty_b;
	assign reports.trades_done = out_q.trades_done;
	assign reports.status      = out_q.status;
	assign reports.outcome     = out_q.outcome;
	assign reports.last        = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (reports.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_valid_q <= '0;
			ctr_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (orders.valid) begin
						cmd_q       <= cmd_t'(orders.cmd);
						nid_q       <= orders.new_order_id;
						tid_q       <= orders.target_id;
						buy_q       <= orders.buy_side;
						lim_q       <= orders.limit_price;
						amt_q       <= orders.amount;
						mkt_q       <= orders.is_market;
						tif_q       <= tif_t'(orders.tif);
						grp_q       <= orders.stp_group;
						pol_q       <= stp_t'(orders.stp_rule);
						idx_q       <= '0;
						tgt_found_q <= 1'b0;
						dup_q       <= 1'b0;
						state_q     <= S_FIND;
					end
				end
				S_FIND: begin
					if (rd_valid && rd_id == tid_q && !tgt_found_q) begin
						tgt_found_q <= 1'b1;
						tgt_q       <= idx_q;
					end
					if (rd_valid && rd_id == nid_q) begin
						dup_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + idx_t'(1);
					end
				end
				S_DECIDE: begin
					tgt_qty_q <= rd_qty;
					fin_oc_q  <= OC_NONE;
					fin_qa_q  <= '0;
					fin_qb_q  <= '0;
					nt_q      <= '0;
					dec_q     <= 1'b0;
					visited_q <= '0;
					idx_q     <= '0;
					bfound_q  <= 1'b0;
					need_q    <= amt_q;
					rem_q     <= amt_q;
					if (cmd_q != CMD_ADD && !tgt_found_q) begin
						fin_st_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						case (cmd_q)
							CMD_CANCEL: begin
								slot_valid_q[tgt_q] <= 1'b0;
								fin_st_q <= ST_CANCELLED;
								fin_qa_q <= rd_qty;
								state_q  <= S_FIN;
							end
							CMD_REDUCE: begin
								fin_qa_q <= rd_qty;
								state_q  <= S_FIN;
								if (rd_qty < amt_q) begin
									fin_st_q <= ST_BAD_QTY;
									fin_qb_q <= rd_qty;
								end else if (rd_qty == amt_q) begin
									slot_valid_q[tgt_q] <= 1'b0;
									fin_st_q <= ST_CANCELLED;
								end else begin
									slot_qty_q[tgt_q] <= rd_qty - amt_q;
									fin_st_q <= ST_REDUCED;
									fin_qb_q <= rd_qty - amt_q;
								end
							end
							default: begin
								if (dup_q && (cmd_q == CMD_ADD || nid_q != tid_q)) begin
									fin_st_q <= ST_DUPLICATE;
									fin_qb_q <= (cmd_q == CMD_ADD) ? amt_q : rd_qty;
									state_q  <= S_FIN;
								end else if (tif_q == TIF_FOK) begin
									fok_q   <= 1'b1;
									state_q <= S_SRCH;
								end else begin
									fok_q <= 1'b0;
									if (cmd_q == CMD_REPLACE) begin
										slot_valid_q[tgt_q] <= 1'b0;
									end
									state_q <= (amt_q == 32'd0) ? S_AFTER : S_SRCH;
								end
							end
						endcase
					end
				end
				S_SRCH: begin
					if (elig && take) begin
						bfound_q     <= 1'b1;
						best_q       <= idx_q;
						best_price_q <= rd_price;
						best_age_q   <= rd_age;
					end
					if (scan_end) begin
						if (bfound_q || elig) begin
							state_q <= S_STEP;
						end else if (fok_q) begin
							fin_st_q <= ST_NO_FILL;
							fin_qb_q <= (cmd_q == CMD_ADD) ? amt_q : tgt_qty_q;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_AFTER;
						end
					end else begin
						idx_q <= idx_q + idx_t'(1);
					end
				end
				S_STEP: begin
					if (fok_q) begin
						idx_q    <= '0;
						bfound_q <= 1'b0;
						if (fail_stp) begin
							fin_st_q <= ST_NO_FILL;
							fin_qb_q <= (cmd_q == CMD_ADD) ? amt_q : tgt_qty_q;
							state_q  <= S_FIN;
						end else if (stp_hit && pol_q == STP_CANCEL_RESTING) begin
							visited_q[best_q] <= 1'b1;
							state_q <= S_SRCH;
						end else if (rd_qty >= need_q) begin
							// The check passed: run the real match from a clean walk.
							fok_q     <= 1'b0;
							visited_q <= '0;
							if (cmd_q == CMD_REPLACE) begin
								slot_valid_q[tgt_q] <= 1'b0;
							end
							state_q <= (amt_q == 32'd0) ? S_AFTER : S_SRCH;
						end else begin
							need_q <= need_q - rd_qty;
							visited_q[best_q] <= 1'b1;
							state_q <= S_SRCH;
						end
					end else if (out_free) begin
						idx_q    <= '0;
						bfound_q <= 1'b0;
						if (stp_hit && pol_q == STP_CANCEL_NEW) begin
							fin_st_q <= ST_ACCEPTED;
							fin_oc_q <= OC_STP_NEW;
							fin_qb_q <= rem_q;
							state_q  <= S_FIN;
						end else if (stp_hit && pol_q == STP_CANCEL_BOTH) begin
							slot_valid_q[best_q] <= 1'b0;
							fin_st_q <= ST_ACCEPTED;
							fin_oc_q <= OC_STP_BOTH;
							fin_qb_q <= rem_q;
							state_q  <= S_FIN;
						end else if (stp_hit && pol_q == STP_CANCEL_RESTING) begin
							slot_valid_q[best_q] <= 1'b0;
							state_q <= S_SRCH;
						end else begin
							if (stp_hit) begin
								dec_q <= 1'b1;
							end else begin
								out_q.is_trade      <= 1'b1;
								out_q.resting_id    <= rd_id;
								out_q.trade_price   <= rd_price;
								out_q.qty_a         <= tq;
								out_q.qty_b         <= rem_q - tq;
								out_q.trades_done   <= nt_q + 6'd1;
								out_q.status        <= ST_ACCEPTED;
								out_q.outcome       <= OC_NONE;
								out_q.last          <= 1'b0;
								nt_q                <= nt_q + 6'd1;
							end
							rem_q <= rem_q - tq;
							slot_qty_q[best_q] <= rd_qty - tq;
							if (rd_qty == tq) begin
								slot_valid_q[best_q] <= 1'b0;
							end
							state_q <= (rem_q == tq) ? S_AFTER : S_SRCH;
						end
					end
				end
				S_AFTER: begin
					fin_st_q <= ST_ACCEPTED;
					fin_qb_q <= rem_q;
					idx_q    <= '0;
					if (rem_q == 32'd0) begin
						fin_oc_q <= dec_q ? OC_STP_DEC_FILLED : OC_FILLED;
						state_q  <= S_FIN;
					end else if ((tif_q == TIF_GTC || tif_q == TIF_GFD) && !mkt_q) begin
						state_q <= S_FREE;
					end else begin
						fin_oc_q <= OC_REM_CANCELLED;
						state_q  <= S_FIN;
					end
				end
				S_FREE: begin
					if (!rd_valid) begin
						slot_valid_q[idx_q] <= 1'b1;
						slot_id_q[idx_q]    <= nid_q;
						slot_buy_q[idx_q]   <= buy_q;
						slot_price_q[idx_q] <= lim_q;
						slot_qty_q[idx_q]   <= rem_q;
						slot_grp_q[idx_q]   <= grp_q;
						slot_arr_q[idx_q]   <= ctr_q;
						ctr_q    <= ctr_q + 32'd1;
						fin_oc_q <= dec_q ? OC_STP_DEC_RESTED : OC_RESTED;
						state_q  <= S_FIN;
					end else if (scan_end) begin
						fin_st_q <= ST_BOOK_FULL;
						fin_oc_q <= OC_NONE;
						state_q  <= S_FIN;
					end else begin
						idx_q <= idx_q + idx_t'(1);
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q.is_trade    <= 1'b0;
						out_q.resting_id  <= '0;
						out_q.trade_price <= '0;
						out_q.qty_a       <= fin_qa_q;
						out_q.qty_b       <= fin_qb_q;
						out_q.trades_done <= nt_q;
						out_q.status      <= fin_st_q;
						out_q.outcome     <= fin_oc_q;
						out_q.last        <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_trade_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_trade |-> out_q.trades_done != 6'd0)
		else $error("trade item without a trade count");

	a_reject_no_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.is_trade && out_q.status != ST_ACCEPTED
		|-> out_q.outcome == OC_NONE)
		else $error("rejected command carries an outcome");

	a_trade_then_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> state_q != S_IDLE)
		else $error("trade item pending while sequencer is idle");

	a_trade_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_trade |-> !out_q.last)
		else $error("trade item marked as final");
`endif
endmodule
